// ===== hw/rtl/cfpd_pkg.sv =====
// Package for the framed packet deframer: codes, controller state, command/status
// structs, the CRC-16/MODBUS byte update and the type/length acceptance check.
// No dependencies.
package cfpd_pkg;

    localparam logic [7:0]  HDR_A         = 8'hAA;
    localparam logic [7:0]  HDR_B         = 8'h55;
    localparam logic [7:0]  FRAME_VERSION = 8'h01;
    localparam int          FRAME_OVERHEAD = 13;
    localparam int          HDR_BYTES     = 11;
    localparam int          POS_VERSION   = 2;
    localparam int          POS_TYPE      = 3;
    localparam int          POS_LEN       = 10;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;

    // message type codes
    localparam logic [7:0] TYPE_BOOL     = 8'h01;
    localparam logic [7:0] TYPE_BULK     = 8'h02;
    localparam logic [7:0] TYPE_PAIR_A   = 8'h10;
    localparam logic [7:0] TYPE_PAIR_B   = 8'h11;
    localparam logic [7:0] TYPE_PAIR_C   = 8'h20;
    localparam logic [7:0] TYPE_EMPTY_A  = 8'h12;
    localparam logic [7:0] TYPE_EMPTY_B  = 8'h13;
    localparam logic [7:0] TYPE_EMPTY_C  = 8'h14;
    localparam logic [7:0] TYPE_EMPTY_D  = 8'h15;
    localparam logic [7:0] TYPE_SEVEN    = 8'h21;
    localparam logic [7:0] TYPE_VAR      = 8'h7E;

    localparam logic [7:0] LEN_BULK      = 8'd72;
    localparam logic [7:0] LEN_PAIR      = 8'd2;
    localparam logic [7:0] LEN_SEVEN     = 8'd7;
    localparam logic [7:0] LEN_VAR_MAX   = 8'd16;

    typedef enum logic [1:0] {
        ST_RECV,
        ST_FETCH,
        ST_LOAD
    } cfpd_state_t;

    typedef struct packed {
        logic take_byte;
        logic load_out;
        logic next_word;
    } cfpd_cmd_t;

    typedef struct packed {
        logic frame_ok;
        logic last_word;
    } cfpd_stat_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic type_fits(input logic [7:0] msg, input logic [7:0] plen,
                                       input logic [7:0] first_byte);
        logic ok;
        case (msg) inside
            TYPE_BOOL:                                         ok = (plen == 8'd1) &&
                                                                    (first_byte <= 8'd1);
            TYPE_BULK:                                         ok = (plen == LEN_BULK);
            TYPE_PAIR_A, TYPE_PAIR_B, TYPE_PAIR_C:             ok = (plen == LEN_PAIR);
            TYPE_EMPTY_A, TYPE_EMPTY_B, TYPE_EMPTY_C, TYPE_EMPTY_D: ok = (plen == 8'd0);
            TYPE_SEVEN:                                        ok = (plen == LEN_SEVEN);
            TYPE_VAR:                                          ok = (plen >= 8'd1) &&
                                                                    (plen <= LEN_VAR_MAX);
            default:                                           ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

// ===== hw/rtl/cfpd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cfpd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 12
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/cfpd_ctrl.sv =====
// Controller for the deframer: receive bytes, then fetch and hand out payload words.
// Depends on cfpd_pkg.
module cfpd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    output cfpd_pkg::cfpd_cmd_t cmd,
    input  cfpd_pkg::cfpd_stat_t stat
);
    import cfpd_pkg::*;

    cfpd_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        can_load;

    // output register free, or its transfer completes this cycle
    assign can_load = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RECV;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RECV:
            begin
                if (in_valid && stat.frame_ok)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (can_load)
                begin
                    state_next = stat.last_word ? ST_RECV : ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_RECV;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_RECV:
            begin
                in_stall      = 1'b0;
                cmd.take_byte = in_valid;
            end
            ST_FETCH:
            begin
            end
            ST_LOAD:
            begin
                if (can_load)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.next_word  = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/cfpd_dpath.sv =====
// Datapath for the deframer: frame position tracking, CRC, header capture,
// payload word assembly into RAM and the output register. Depends on cfpd_pkg.
module cfpd_dpath #(
    parameter int MAX_PAYLOAD = 96,
    parameter int WORD_BYTES  = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfpd_pkg::cfpd_cmd_t       cmd,
    output cfpd_pkg::cfpd_stat_t      stat,
    input  logic [7:0]                rx_byte,
    output logic                      ram_wr_en,
    output logic [((((MAX_PAYLOAD + WORD_BYTES - 1) / WORD_BYTES) > 1) ?
                   $clog2((MAX_PAYLOAD + WORD_BYTES - 1) / WORD_BYTES) : 1)-1:0] ram_wr_addr,
    output logic [WORD_BYTES*8-1:0]   ram_wr_data,
    output logic [((((MAX_PAYLOAD + WORD_BYTES - 1) / WORD_BYTES) > 1) ?
                   $clog2((MAX_PAYLOAD + WORD_BYTES - 1) / WORD_BYTES) : 1)-1:0] ram_rd_addr,
    input  logic [WORD_BYTES*8-1:0]   ram_rd_data,
    output logic [7:0]                msg_type,
    output logic [7:0]                src_role,
    output logic [7:0]                src_group,
    output logic [7:0]                dst_role,
    output logic [7:0]                dst_group,
    output logic [15:0]               flow_id,
    output logic [6:0]                payload_len,
    output logic [3:0]                word_index,
    output logic [63:0]               payload_word,
    output logic                      last
);
    import cfpd_pkg::*;

    localparam int NWORDS  = (MAX_PAYLOAD + WORD_BYTES - 1) / WORD_BYTES;
    localparam int AW      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int WW      = WORD_BYTES * 8;
    localparam int LANE_W  = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
    localparam int CNT_W   = $clog2(FRAME_OVERHEAD + MAX_PAYLOAD + 1);
    localparam int MAX_CNT = FRAME_OVERHEAD + MAX_PAYLOAD;

    logic [CNT_W-1:0]  byte_count_reg, byte_count_next;
    logic [CNT_W-1:0]  expected_total_reg, expected_total_next;
    logic [15:0]       crc_reg, crc_next;
    logic [7:0]        hdr_reg [POS_VERSION:POS_LEN];
    logic [7:0]        first_byte_reg;
    logic [7:0]        crc_low_reg;
    logic [WW-1:0]     acc_reg, acc_next;
    logic [LANE_W-1:0] lane_reg, lane_next;
    logic [AW-1:0]     waddr_reg, waddr_next;
    logic [AW-1:0]     last_word_reg, last_word_next;
    logic [AW-1:0]     word_cnt_reg;

    logic [7:0]        msg_type_reg, src_role_reg, src_group_reg, dst_role_reg, dst_group_reg;
    logic [15:0]       flow_id_reg;
    logic [6:0]        payload_len_reg;
    logic [3:0]        word_index_reg;
    logic [63:0]       payload_word_reg;
    logic              last_reg;

    logic [CNT_W-1:0]  pos;
    logic [CNT_W-1:0]  pos_inc;
    logic [7:0]        plen;
    logic [CNT_W-1:0]  pay_end;
    logic              in_header, in_payload, is_crc_low, overrun;
    logic              frame_end, frame_good;
    logic              flush;
    logic [WW-1:0]     merged;

    assign pos     = byte_count_reg;
    assign pos_inc = byte_count_reg + CNT_W'(1);
    assign plen    = hdr_reg[POS_LEN];
    assign pay_end = CNT_W'(HDR_BYTES) + CNT_W'(plen);

    assign overrun    = (pos >= CNT_W'(MAX_CNT));
    assign in_header  = (pos >= CNT_W'(POS_VERSION)) && (pos < CNT_W'(HDR_BYTES));
    assign in_payload = (pos >= CNT_W'(HDR_BYTES)) && (pos < pay_end) && !overrun;
    assign is_crc_low = (pos >= CNT_W'(HDR_BYTES)) && (pos == pay_end) && !overrun;

    // expected_total is nonzero only after the length byte, so pos is past the header here
    assign frame_end  = (expected_total_reg != '0) && (pos_inc == expected_total_reg) &&
                        !overrun;
    assign frame_good = (hdr_reg[POS_VERSION] == FRAME_VERSION) &&
                        (crc_low_reg == crc_reg[7:0]) && (rx_byte == crc_reg[15:8]) &&
                        type_fits(hdr_reg[POS_TYPE], plen, first_byte_reg);

    assign stat.frame_ok  = frame_end && frame_good;
    assign stat.last_word = (word_cnt_reg == last_word_reg);

    assign merged = acc_reg | (WW'(rx_byte) << {lane_reg, 3'b000});
    assign flush  = (lane_reg == LANE_W'(WORD_BYTES - 1)) || (pos_inc == pay_end);

    assign ram_wr_en   = cmd.take_byte && in_payload && flush;
    assign ram_wr_addr = waddr_reg;
    assign ram_wr_data = merged;
    assign ram_rd_addr = word_cnt_reg;

    always_comb
    begin
        byte_count_next     = byte_count_reg;
        expected_total_next = expected_total_reg;
        crc_next            = crc_reg;
        acc_next            = acc_reg;
        lane_next           = lane_reg;
        waddr_next          = waddr_reg;
        last_word_next      = last_word_reg;
        if (cmd.take_byte)
        begin
            if (pos == '0)
            begin
                if (rx_byte == HDR_A)
                begin
                    byte_count_next = CNT_W'(1);
                end
            end
            else if (pos == CNT_W'(1))
            begin
                if (rx_byte == HDR_B)
                begin
                    byte_count_next = CNT_W'(2);
                end
                else if (rx_byte != HDR_A)
                begin
                    byte_count_next = '0;
                    expected_total_next = '0;
                    crc_next = CRC_INIT;
                end
            end
            else if (overrun)
            begin
                byte_count_next     = '0;
                expected_total_next = '0;
                crc_next            = CRC_INIT;
            end
            else
            begin
                byte_count_next = pos_inc;
                if (in_header)
                begin
                    crc_next       = crc_feed((pos == CNT_W'(POS_VERSION)) ? CRC_INIT : crc_reg,
                                              rx_byte);
                    acc_next       = '0;
                    lane_next      = '0;
                    waddr_next     = '0;
                    last_word_next = '0;
                end
                else if (in_payload)
                begin
                    crc_next = crc_feed(crc_reg, rx_byte);
                    if (flush)
                    begin
                        acc_next       = '0;
                        lane_next      = '0;
                        waddr_next     = waddr_reg + AW'(1);
                        last_word_next = waddr_reg;
                    end
                    else
                    begin
                        acc_next  = merged;
                        lane_next = lane_reg + LANE_W'(1);
                    end
                end
                if (pos == CNT_W'(POS_LEN))
                begin
                    if (rx_byte > 8'(MAX_PAYLOAD))
                    begin
                        byte_count_next     = '0;
                        expected_total_next = '0;
                        crc_next            = CRC_INIT;
                    end
                    else
                    begin
                        expected_total_next = CNT_W'(FRAME_OVERHEAD) + CNT_W'(rx_byte);
                    end
                end
                else if (frame_end)
                begin
                    byte_count_next     = '0;
                    expected_total_next = '0;
                    crc_next            = CRC_INIT;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg     <= '0;
            expected_total_reg <= '0;
            crc_reg            <= CRC_INIT;
            lane_reg           <= '0;
            waddr_reg          <= '0;
            last_word_reg      <= '0;
            word_cnt_reg       <= '0;
        end
        else
        begin
            byte_count_reg     <= byte_count_next;
            expected_total_reg <= expected_total_next;
            crc_reg            <= crc_next;
            lane_reg           <= lane_next;
            waddr_reg          <= waddr_next;
            last_word_reg      <= last_word_next;
            if (cmd.take_byte)
            begin
                word_cnt_reg <= '0;
            end
            else if (cmd.next_word)
            begin
                word_cnt_reg <= word_cnt_reg + AW'(1);
            end
        end
    end

    // payload-side registers, no reset
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (cmd.take_byte && !overrun && (pos > CNT_W'(1)))
        begin
            for (int i = POS_VERSION; i <= POS_LEN; i++)
            begin
                if (pos == CNT_W'(i))
                begin
                    hdr_reg[i] <= rx_byte;
                end
            end
            if (in_payload && (pos == CNT_W'(HDR_BYTES)))
            begin
                first_byte_reg <= rx_byte;
            end
            if (is_crc_low)
            begin
                crc_low_reg <= rx_byte;
            end
        end
        if (cmd.load_out)
        begin
            msg_type_reg     <= hdr_reg[3];
            src_role_reg     <= hdr_reg[4];
            src_group_reg    <= hdr_reg[5];
            dst_role_reg     <= hdr_reg[6];
            dst_group_reg    <= hdr_reg[7];
            flow_id_reg      <= {hdr_reg[9], hdr_reg[8]};
            payload_len_reg  <= 7'(plen);
            word_index_reg   <= 4'(word_cnt_reg);
            // empty payload: RAM entry 0 is stale
            payload_word_reg <= (plen == 8'd0) ? 64'd0 : 64'(ram_rd_data);
            last_reg         <= stat.last_word;
        end
    end

    assign msg_type     = msg_type_reg;
    assign src_role     = src_role_reg;
    assign src_group    = src_group_reg;
    assign dst_role     = dst_role_reg;
    assign dst_group    = dst_group_reg;
    assign flow_id      = flow_id_reg;
    assign payload_len  = payload_len_reg;
    assign word_index   = word_index_reg;
    assign payload_word = payload_word_reg;
    assign last         = last_reg;

endmodule

// ===== hw/rtl/crc_framed_packet_deframer_unit.sv =====
// Top level of the CRC-16/MODBUS framed packet deframer.
// Depends on cfpd_pkg, cfpd_ram, cfpd_ctrl and cfpd_dpath.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_stall  | rx_byte
//  out     | out_valid / out_stall| msg_type src_role src_group dst_role dst_group
//          |                      | flow_id payload_len word_index payload_word last
//
// One byte is taken per cycle while a frame is being received.
// After the final byte of a good frame the input stalls while its words go out; each
// word passes a fetch state, for the registered read of the payload word RAM, then a load state.
// Reset is asynchronous; no memory clearing pass is needed.
// out_stall holds the output register; the last word may wait there while the
// next frame's bytes are already being taken.
module crc_framed_packet_deframer_unit #(
    parameter int MAX_PAYLOAD = 96,
    parameter int WORD_BYTES  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  msg_type,
    output logic [7:0]  src_role,
    output logic [7:0]  src_group,
    output logic [7:0]  dst_role,
    output logic [7:0]  dst_group,
    output logic [15:0] flow_id,
    output logic [6:0]  payload_len,
    output logic [3:0]  word_index,
    output logic [63:0] payload_word,
    output logic        last
);
    import cfpd_pkg::*;

    localparam int NWORDS = (MAX_PAYLOAD + WORD_BYTES - 1) / WORD_BYTES;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int WW     = WORD_BYTES * 8;

    cfpd_cmd_t  cmd;
    cfpd_stat_t stat;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [WW-1:0] ram_wr_data;
    logic [AW-1:0] ram_rd_addr;
    logic [WW-1:0] ram_rd_data;

    cfpd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    cfpd_dpath #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .WORD_BYTES  (WORD_BYTES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .rx_byte      (rx_byte),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data),
        .msg_type     (msg_type),
        .src_role     (src_role),
        .src_group    (src_group),
        .dst_role     (dst_role),
        .dst_group    (dst_group),
        .flow_id      (flow_id),
        .payload_len  (payload_len),
        .word_index   (word_index),
        .payload_word (payload_word),
        .last         (last)
    );

    cfpd_ram #(
        .WIDTH (WW),
        .DEPTH (NWORDS)
    ) u_word_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

// ===== test/tb_top.sv =====
// Testbench for crc_framed_packet_deframer_unit: sends framed byte streams with
// random gaps and output stalls; checks output words against a predictor or table.
// Depends on cfpd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module tb_top;
    import cfpd_pkg::*;

    localparam int PAY_MAX     = 96;
    localparam int WORD_LANES  = 8;
    localparam int RAND_BYTES  = 150;
    localparam int SETTLE      = 40;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORT  = 10;
    localparam int NUM_ROWS    = 22;

    typedef enum logic [2:0] {
        FL_NONE,
        FL_BAD_VERSION,
        FL_BAD_CRC,
        FL_DOUBLE_AA,
        FL_BROKEN_SYNC
    } flaw_t;

    typedef enum logic [1:0] {
        PAT_ZERO,
        PAT_ONES,
        PAT_SYNC,
        PAT_RAND
    } fill_t;

    // EXP_MODEL: predictor decides; the others are typed in
    typedef enum logic [1:0] {
        EXP_MODEL,
        EXP_NONE,
        EXP_EMPTY
    } outcome_t;

    typedef struct packed {
        logic [7:0] mtype;
        logic [7:0] plen;
        fill_t      pay;
        fill_t      hdr;
        flaw_t      flaw;
        outcome_t   outcome;
    } frame_row_t;

    typedef struct packed {
        logic [7:0]  mtype;
        logic [7:0]  srole;
        logic [7:0]  sgroup;
        logic [7:0]  drole;
        logic [7:0]  dgroup;
        logic [15:0] flow;
        logic [6:0]  plen;
        logic [3:0]  widx;
        logic [63:0] word;
        logic        fin;
    } out_word_t;

    localparam frame_row_t DIR_ROWS [NUM_ROWS] = '{
        '{TYPE_EMPTY_A, 8'd0,   PAT_ZERO, PAT_ZERO, FL_NONE,        EXP_EMPTY},
        '{TYPE_EMPTY_D, 8'd0,   PAT_ZERO, PAT_ONES, FL_NONE,        EXP_EMPTY},
        '{TYPE_EMPTY_B, 8'd0,   PAT_ZERO, PAT_ONES, FL_DOUBLE_AA,   EXP_EMPTY},
        '{TYPE_EMPTY_C, 8'd0,   PAT_ZERO, PAT_ZERO, FL_BROKEN_SYNC, EXP_EMPTY},
        '{TYPE_BOOL,    8'd1,   PAT_ZERO, PAT_RAND, FL_NONE,        EXP_MODEL},
        '{TYPE_BOOL,    8'd1,   PAT_ONES, PAT_RAND, FL_NONE,        EXP_NONE},
        '{TYPE_BULK,    8'd72,  PAT_RAND, PAT_RAND, FL_NONE,        EXP_MODEL},
        '{TYPE_PAIR_A,  8'd2,   PAT_ONES, PAT_ONES, FL_NONE,        EXP_MODEL},
        '{TYPE_PAIR_B,  8'd2,   PAT_SYNC, PAT_SYNC, FL_DOUBLE_AA,   EXP_MODEL},
        '{TYPE_PAIR_C,  8'd2,   PAT_RAND, PAT_RAND, FL_BROKEN_SYNC, EXP_MODEL},
        '{TYPE_SEVEN,   8'd7,   PAT_SYNC, PAT_RAND, FL_NONE,        EXP_MODEL},
        '{TYPE_VAR,     8'd1,   PAT_RAND, PAT_ZERO, FL_NONE,        EXP_MODEL},
        '{TYPE_VAR,     8'd16,  PAT_ONES, PAT_ONES, FL_NONE,        EXP_MODEL},
        '{TYPE_VAR,     8'd17,  PAT_RAND, PAT_RAND, FL_NONE,        EXP_NONE},
        '{TYPE_VAR,     8'd96,  PAT_RAND, PAT_RAND, FL_NONE,        EXP_NONE},
        '{TYPE_SEVEN,   8'd97,  PAT_RAND, PAT_RAND, FL_NONE,        EXP_NONE},
        '{TYPE_PAIR_A,  8'd255, PAT_RAND, PAT_RAND, FL_NONE,        EXP_NONE},
        '{8'h00,        8'd0,   PAT_ZERO, PAT_ZERO, FL_NONE,        EXP_NONE},
        '{8'hFF,        8'd2,   PAT_RAND, PAT_RAND, FL_NONE,        EXP_NONE},
        '{TYPE_PAIR_A,  8'd2,   PAT_RAND, PAT_RAND, FL_BAD_VERSION, EXP_NONE},
        '{TYPE_SEVEN,   8'd7,   PAT_RAND, PAT_RAND, FL_BAD_CRC,     EXP_NONE},
        '{TYPE_EMPTY_A, 8'd2,   PAT_RAND, PAT_RAND, FL_NONE,        EXP_NONE}
    };

    localparam logic [7:0] TYPE_LIST [11] = '{
        TYPE_BOOL, TYPE_BULK, TYPE_PAIR_A, TYPE_PAIR_B, TYPE_PAIR_C, TYPE_EMPTY_A,
        TYPE_EMPTY_B, TYPE_EMPTY_C, TYPE_EMPTY_D, TYPE_SEVEN, TYPE_VAR
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  msg_type;
    logic [7:0]  src_role;
    logic [7:0]  src_group;
    logic [7:0]  dst_role;
    logic [7:0]  dst_group;
    logic [15:0] flow_id;
    logic [6:0]  payload_len;
    logic [3:0]  word_index;
    logic [63:0] payload_word;
    logic        last;

    // deframer predictor state
    logic [6:0]  frm_cnt;
    logic [6:0]  frm_total;
    logic [15:0] crc_run;
    logic [7:0]  hdr_mem [HDR_BYTES] = '{default: 8'h00};
    logic [7:0]  pay_mem [PAY_MAX] = '{default: 8'h00};
    logic [7:0]  crc_lo = 8'h00;

    out_word_t   staged_words[$];
    out_word_t   expected_words[$];
    logic [7:0]  tx_bytes[$];

    int mismatches = 0;
    int words_total = 0;
    int words_seen = 0;
    int frames_sent = 0;
    int bytes_used = 0;
    int cycles = 0;
    int stall_left = 3;
    bit in_calm = 1'b0;
    bit out_calm = 1'b0;

    crc_framed_packet_deframer_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .msg_type     (msg_type),
        .src_role     (src_role),
        .src_group    (src_group),
        .dst_role     (dst_role),
        .dst_group    (dst_group),
        .flow_id      (flow_id),
        .payload_len  (payload_len),
        .word_index   (word_index),
        .payload_word (payload_word),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles,
                     expected_words.size());
            $display("simulation failed");
            $finish;
        end
    end

    // bit-serial LSB-first form of the reflected CRC-16
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c = c >> 1;
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic void hunt_restart();
        frm_cnt = '0;
        frm_total = '0;
        crc_run = CRC_INIT;
    endfunction

    function automatic logic length_ok(input logic [7:0] t, input int plen);
        case (t)
            TYPE_BOOL:                                   return plen == 1 && pay_mem[0] <= 8'd1;
            TYPE_BULK:                                   return plen == int'(LEN_BULK);
            TYPE_PAIR_A, TYPE_PAIR_B, TYPE_PAIR_C:       return plen == int'(LEN_PAIR);
            TYPE_EMPTY_A, TYPE_EMPTY_B, TYPE_EMPTY_C,
            TYPE_EMPTY_D:                                return plen == 0;
            TYPE_SEVEN:                                  return plen == int'(LEN_SEVEN);
            TYPE_VAR:                                    return plen >= 1 &&
                                                                plen <= int'(LEN_VAR_MAX);
            default:                                     return 1'b0;
        endcase
    endfunction

    // advance the deframer by one byte; words of a good frame go to staged_words
    task automatic deframe_predict(input logic [7:0] b);
        int          pos;
        int          plen;
        int          words;
        int          idx;
        logic [15:0] crc_snap;
        out_word_t   r;
        if (frm_cnt == 0)
        begin
            if (b == HDR_A)
            begin
                hdr_mem[0] = b;
                frm_cnt = 7'd1;
            end
            return;
        end
        if (frm_cnt == 1)
        begin
            if (b == HDR_B)
            begin
                hdr_mem[1] = b;
                frm_cnt = 7'd2;
            end
            else if (b != HDR_A)
                hunt_restart();
            return;
        end
        if (frm_cnt >= FRAME_OVERHEAD + PAY_MAX)
        begin
            hunt_restart();
            return;
        end
        pos = int'(frm_cnt);
        if (pos == POS_VERSION)
            crc_run = CRC_INIT;
        if (pos < HDR_BYTES)
        begin
            hdr_mem[pos] = b;
            crc_run = crc16_step(crc_run, b);
        end
        else
        begin
            plen = int'(hdr_mem[POS_LEN]);
            if (pos < HDR_BYTES + plen)
            begin
                if (pos - HDR_BYTES < PAY_MAX)
                    pay_mem[pos - HDR_BYTES] = b;
                crc_run = crc16_step(crc_run, b);
            end
            else if (pos == HDR_BYTES + plen)
                crc_lo = b;
        end
        frm_cnt = 7'(pos + 1);
        if (frm_cnt == HDR_BYTES)
        begin
            if (b > PAY_MAX)
            begin
                hunt_restart();
                return;
            end
            frm_total = 7'(FRAME_OVERHEAD + b);
        end
        if (frm_total == 0 || frm_cnt != frm_total)
            return;

        crc_snap = crc_run;
        plen = int'(hdr_mem[POS_LEN]);
        hunt_restart();
        if (hdr_mem[POS_VERSION] != FRAME_VERSION)
            return;
        if (crc_lo != crc_snap[7:0] || b != crc_snap[15:8])
            return;
        if (!length_ok(hdr_mem[POS_TYPE], plen))
            return;
        words = (plen == 0) ? 1 : (plen + WORD_LANES - 1) / WORD_LANES;
        for (int w = 0; w < words; w++)
        begin
            r.mtype = hdr_mem[3];
            r.srole = hdr_mem[4];
            r.sgroup = hdr_mem[5];
            r.drole = hdr_mem[6];
            r.dgroup = hdr_mem[7];
            r.flow = {hdr_mem[9], hdr_mem[8]};
            r.plen = 7'(plen);
            r.widx = 4'(w);
            r.word = '0;
            for (int k = 0; k < WORD_LANES; k++)
            begin
                idx = w * WORD_LANES + k;
                if (idx < plen)
                    r.word[8*k +: 8] = pay_mem[idx];
            end
            r.fin = (w == words - 1);
            staged_words.push_back(r);
        end
    endtask

    function automatic logic [7:0] fill_byte(input fill_t f, input int i);
        case (f)
            PAT_ZERO: return 8'h00;
            PAT_ONES: return 8'hFF;
            PAT_SYNC: return i[0] ? HDR_B : HDR_A;
            default:  return 8'($urandom);
        endcase
    endfunction

    task automatic build_frame(input logic [7:0] mtype, input int plen, input fill_t pay,
                               input fill_t hdr, input flaw_t flaw);
        logic [15:0] crc;
        logic [7:0]  b;
        int          start;
        tx_bytes.delete();
        if (flaw == FL_DOUBLE_AA)
            tx_bytes.push_back(HDR_A);
        if (flaw == FL_BROKEN_SYNC)
        begin
            b = 8'($urandom);
            if (b == HDR_A || b == HDR_B)
                b = 8'h00;
            tx_bytes.push_back(HDR_A);
            tx_bytes.push_back(b);
        end
        tx_bytes.push_back(HDR_A);
        tx_bytes.push_back(HDR_B);
        start = tx_bytes.size();
        if (flaw == FL_BAD_VERSION)
            b = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(2, 255));
        else
            b = FRAME_VERSION;
        tx_bytes.push_back(b);
        tx_bytes.push_back(mtype);
        for (int i = 0; i < 6; i++)
            tx_bytes.push_back(fill_byte(hdr, i));
        tx_bytes.push_back(8'(plen));
        // over-length frames end at the length byte
        if (plen > PAY_MAX)
            return;
        for (int i = 0; i < plen; i++)
        begin
            b = fill_byte(pay, i);
            if (mtype == TYPE_BOOL && pay == PAT_RAND && i == 0 && $urandom_range(0, 3) != 0)
                b = 8'($urandom_range(0, 1));
            tx_bytes.push_back(b);
        end
        crc = CRC_INIT;
        for (int i = start; i < tx_bytes.size(); i++)
            crc = crc16_step(crc, tx_bytes[i]);
        if (flaw == FL_BAD_CRC)
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        tx_bytes.push_back(crc[7:0]);
        tx_bytes.push_back(crc[15:8]);
    endtask

    task automatic random_frame();
        logic [7:0] t;
        int         plen;
        int         roll;
        flaw_t      fl;
        fill_t      pf;
        fill_t      hf;
        roll = $urandom_range(0, 11);
        t = (roll == 11) ? 8'($urandom) : TYPE_LIST[roll];
        // keep the long bulk frames rare
        if (t == TYPE_BULK && $urandom_range(0, 2) != 0)
            t = TYPE_VAR;
        case (t)
            TYPE_BOOL:                                   plen = 1;
            TYPE_BULK:                                   plen = int'(LEN_BULK);
            TYPE_PAIR_A, TYPE_PAIR_B, TYPE_PAIR_C:       plen = int'(LEN_PAIR);
            TYPE_EMPTY_A, TYPE_EMPTY_B, TYPE_EMPTY_C,
            TYPE_EMPTY_D:                                plen = 0;
            TYPE_SEVEN:                                  plen = int'(LEN_SEVEN);
            TYPE_VAR:                                    plen = $urandom_range(1, 16);
            default:                                     plen = $urandom_range(0, 20);
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 6)
            plen = $urandom_range(0, 24);
        else if (roll < 9)
            plen = $urandom_range(PAY_MAX + 1, 255);
        roll = $urandom_range(0, 99);
        fl = (roll < 70) ? FL_NONE : (roll < 78) ? FL_BAD_CRC :
             (roll < 84) ? FL_BAD_VERSION : (roll < 92) ? FL_DOUBLE_AA : FL_BROKEN_SYNC;
        pf = ($urandom_range(0, 9) == 0) ? fill_t'($urandom_range(0, 3)) : PAT_RAND;
        hf = ($urandom_range(0, 9) == 0) ? fill_t'($urandom_range(0, 3)) : PAT_RAND;
        build_frame(t, plen, pf, hf, fl);
    endtask

    // one input transfer; keep selects whether predicted words become expected
    task automatic send_byte(input logic [7:0] b, input bit keep);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, 13);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_used++;
        deframe_predict(b);
        while (staged_words.size() != 0)
        begin
            if (keep)
            begin
                expected_words.push_back(staged_words[0]);
                words_total++;
            end
            void'(staged_words.pop_front());
        end
    endtask

    task automatic send_frame(input outcome_t outcome, input logic [7:0] mtype,
                              input logic [7:0] hb);
        out_word_t r;
        frames_sent++;
        foreach (tx_bytes[i])
            send_byte(tx_bytes[i], outcome == EXP_MODEL);
        if (outcome == EXP_EMPTY)
        begin
            r = '{mtype, hb, hb, hb, hb, {hb, hb}, 7'd0, 4'd0, 64'd0, 1'b1};
            expected_words.push_back(r);
            words_total++;
        end
    endtask

    // zeros flush a partial frame without starting a new one
    task automatic resync();
        while (frm_cnt != 0)
            send_byte(8'h00, 1'b1);
    endtask

    task automatic show_word(input string tag, input out_word_t w);
        $display("  %s type=%h src=%h/%h dst=%h/%h flow=%h len=%0d word[%0d]=%h last=%b",
                 tag, w.mtype, w.srole, w.sgroup, w.drole, w.dgroup, w.flow, w.plen,
                 w.widx, w.word, w.fin);
    endtask

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : check_out
        out_word_t got;
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{msg_type, src_role, src_group, dst_role, dst_group, flow_id,
                    payload_len, word_index, payload_word, last};
            words_seen++;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORT)
                begin
                    $display("unexpected output word at cycle %0d", cycles);
                    show_word("act", got);
                end
            end
            else
            begin
                want = expected_words.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORT)
                    begin
                        $display("output word mismatch at cycle %0d", cycles);
                        show_word("exp", want);
                        show_word("act", got);
                    end
                end
            end
            if ($urandom_range(0, 15) == 0)
                out_calm = !out_calm;
            stall_left = out_calm ? 0 : $urandom_range(0, 13);
        end
    end

    initial
    begin
        frame_row_t row;
        int         pick;
        int         cut;
        int         n;
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = 8'h00;
        hunt_restart();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIR_ROWS[i])
        begin
            row = DIR_ROWS[i];
            in_calm = (i % 3 == 0);
            build_frame(row.mtype, row.plen, row.pay, row.hdr, row.flaw);
            send_frame(row.outcome, row.mtype, (row.hdr == PAT_ONES) ? 8'hFF : 8'h00);
        end

        bytes_used = 0;
        while (bytes_used < RAND_BYTES)
        begin
            in_calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    send_byte(8'($urandom), 1'b1);
                resync();
            end
            else
            begin
                random_frame();
                if (pick < 22)
                begin
                    // truncated frame, then flushed
                    cut = $urandom_range(1, tx_bytes.size() - 1);
                    for (int i = 0; i < cut; i++)
                        send_byte(tx_bytes[i], 1'b1);
                    resync();
                end
                else
                    send_frame(EXP_MODEL, 8'h00, 8'h00);
            end
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("%0d frames plus noise and cut-off frames sent in %0d cycles", frames_sent,
                 cycles);
        $display("%0d output words expected, %0d checked, %0d mismatches", words_total,
                 words_seen, mismatches);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/cfpd_pkg.sv
hw/rtl/cfpd_ram.sv
hw/rtl/cfpd_ctrl.sv
hw/rtl/cfpd_dpath.sv
hw/rtl/crc_framed_packet_deframer_unit.sv
test/tb_top.sv
